// ===== design/mpr_pkg.sv =====
// Shared constants, types and helper functions of the MaxCut phase rotator.
`default_nettype none
package mpr_pkg;

	localparam int DEF_MAX_QUBITS = 16;
	localparam int ROW_W = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;

	typedef enum logic [1:0] {
		REG_HALF_ANGLE = 2'd0,
		REG_FIRST_LAYER = 2'd1,
		REG_UNIFORM_AMP = 2'd2,
		REG_QUBITS = 2'd3
	} cfg_reg_t;

	function automatic logic [4:0] popcnt16(input logic [ROW_W-1:0] v);
		logic [4:0] n;
		n = '0;
		for (int k = 0; k < ROW_W; k++) n = n + 5'(v[k]);
		return n;
	endfunction

	// atan(2^-i) in 2^-32 turn, rounded
	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0: a = 32'd536870912;
			5'd1: a = 32'd316933406;
			5'd2: a = 32'd167458907;
			5'd3: a = 32'd85004756;
			5'd4: a = 32'd42667331;
			5'd5: a = 32'd21354465;
			5'd6: a = 32'd10679838;
			5'd7: a = 32'd5340245;
			5'd8: a = 32'd2670163;
			5'd9: a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// ===== design/maxcut_phase_rotator_top.sv =====
// MaxCut cost-phase rotator: rotates one state amplitude by the cut-dependent phase.
//
// Input stream s_*: s_tuser is the mode. Mode 0 loads one adjacency row (no result);
// mode 1 carries a basis index and a Q1.30 complex amplitude and yields one result
// on m_* (rotated amplitude, saturated Q1.30, and the cut count).
// Configuration: cfg_we/cfg_addr/cfg_wdata write a register on the clock edge;
// write only while the pipeline is empty.
// Requests pass, in order, row count, sum, phase multiply, range reduction, the 30
// CORDIC stages, quadrant fix, complex multiply and round to the output register.
// Throughput: one request per cycle while the receiver does not stall; one pipeline stage per CORDIC iteration.
// Reset clears all adjacency rows and sets the registers to their defaults.
// When the receiver stalls with a result waiting in the output register, the
// whole pipeline holds and s_tready drops; nothing is lost or repeated.
// A row load changes the rows seen by every request that follows it.
`default_nettype none
module maxcut_phase_rotator_top #(
	parameter int MAX_QUBITS = mpr_pkg::DEF_MAX_QUBITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// row_index[3:0], row_bits[19:4], basis_index[35:20], amp_re[67:36], amp_im[99:68]
	input  wire logic [103:0] s_tdata,
	// mode
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_re[31:0], out_im[63:32], cut_count[72:64]
	output logic [79:0]       m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [31:0]  cfg_wdata
);
	localparam int RW = mpr_pkg::ROW_W;
	localparam int NS = mpr_pkg::CORDIC_STEPS;
	localparam int CW = mpr_pkg::CW;
	localparam int SW = $clog2(MAX_QUBITS * RW + 1);

	logic [31:0] half_angle_q;
	logic        first_layer_q;
	logic [30:0] uniform_amp_q;
	logic [4:0]  qubits_q;
	logic [RW-1:0] rows_q [MAX_QUBITS];

	logic en;
	logic acc;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign acc = s_tvalid && s_tready;

	logic [3:0]  in_row;
	logic [RW-1:0] in_bits, in_idx;
	logic [31:0] in_re, in_im;
	assign in_row  = s_tdata[3:0];
	assign in_bits = s_tdata[19:4];
	assign in_idx  = s_tdata[35:20];
	assign in_re   = s_tdata[67:36];
	assign in_im   = s_tdata[99:68];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_angle_q <= '0;
			first_layer_q <= 1'b1;
			uniform_amp_q <= '0;
			qubits_q <= 5'd16;
		end else if (cfg_we) begin
			case (mpr_pkg::cfg_reg_t'(cfg_addr))
				mpr_pkg::REG_HALF_ANGLE: half_angle_q <= cfg_wdata;
				mpr_pkg::REG_FIRST_LAYER: first_layer_q <= cfg_wdata[0];
				mpr_pkg::REG_UNIFORM_AMP: uniform_amp_q <= cfg_wdata[30:0];
				mpr_pkg::REG_QUBITS: qubits_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// row store; rows past row_index range stay zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_QUBITS; i++) rows_q[i] <= '0;
		end else begin
			for (int i = 0; i < MAX_QUBITS; i++) begin
				if (acc && !s_tuser && ({2'b00, in_row} == 6'(i))) rows_q[i] <= in_bits;
			end
		end
	end

	// row limit: qubit count saturated to MAX_QUBITS
	logic [5:0] limit;
	assign limit = ({1'b0, qubits_q} > 6'(MAX_QUBITS)) ? 6'(MAX_QUBITS) : {1'b0, qubits_q};

	// stage 1: per-row counts
	logic [4:0] cut_r_s1 [MAX_QUBITS];
	logic [4:0] edg_r_s1 [MAX_QUBITS];
	logic [31:0] re_s1, im_s1;
	logic v_s1;

	for (genvar g = 0; g < MAX_QUBITS; g++) begin : g_row
		logic bit_i;
		logic use_i;
		if (g < RW) begin : g_lo
			assign bit_i = in_idx[g];
		end else begin : g_hi
			assign bit_i = 1'b0;
		end
		assign use_i = 6'(g) < limit;
		always_ff @(posedge clk) begin
			if (en) begin
				cut_r_s1[g] <= use_i ?
					mpr_pkg::popcnt16(rows_q[g] & (bit_i ? ~in_idx : in_idx)) : 5'd0;
				edg_r_s1[g] <= use_i ? mpr_pkg::popcnt16(rows_q[g]) : 5'd0;
			end
		end
	end

	// stage 2: totals
	logic [SW-1:0] cut_s2, edg_s2;
	logic [31:0] re_s2, im_s2;
	logic v_s2;
	logic [SW-1:0] cut_sum, edg_sum;
	always_comb begin
		cut_sum = '0;
		edg_sum = '0;
		for (int i = 0; i < MAX_QUBITS; i++) begin
			cut_sum = cut_sum + SW'(cut_r_s1[i]);
			edg_sum = edg_sum + SW'(edg_r_s1[i]);
		end
	end

	// stage 3: phase
	logic [31:0] phase_s3;
	logic [8:0]  cut_s3;
	logic [31:0] re_s3, im_s3;
	logic v_s3;
	logic [31:0] diff;
	assign diff = (32'(cut_s2) << 1) - 32'(edg_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			re_s1 <= in_re;
			im_s1 <= in_im;
			cut_s2 <= cut_sum;
			edg_s2 <= edg_sum;
			re_s2 <= re_s1;
			im_s2 <= im_s1;
			phase_s3 <= 32'(half_angle_q * diff);
			cut_s3 <= 9'(cut_s2);
			re_s3 <= re_s2;
			im_s3 <= im_s2;
		end
	end

	// CORDIC: stage 0 holds the reduced start values, stage i+1 is iteration i
	logic [1:0] q0;
	logic [31:0] r0;
	assign q0 = 2'((phase_s3 + 32'h2000_0000) >> 30);
	assign r0 = phase_s3 - {q0, 30'd0};

	logic signed [CW-1:0] cx_s [NS+1];
	logic signed [CW-1:0] cy_s [NS+1];
	logic signed [CW-1:0] cz_s [NS+1];
	logic [1:0]  cq_s  [NS+1];
	logic [8:0]  ccut_s [NS+1];
	logic [31:0] cre_s [NS+1];
	logic [31:0] cim_s [NS+1];
	logic        cv_s  [NS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= mpr_pkg::CORDIC_GAIN;
			cy_s[0] <= '0;
			cz_s[0] <= CW'(signed'(r0));
			cq_s[0] <= q0;
			ccut_s[0] <= cut_s3;
			cre_s[0] <= re_s3;
			cim_s[0] <= im_s3;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [CW-1:0] dx, dy, at;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign at = CW'(mpr_pkg::atan_turns(5'(i)));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[i][CW-1]) begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - at;
				end else begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + at;
				end
				cq_s[i+1] <= cq_s[i];
				ccut_s[i+1] <= ccut_s[i];
				cre_s[i+1] <= cre_s[i];
				cim_s[i+1] <= cim_s[i];
			end
		end
	end

	// quadrant fix-up
	logic signed [31:0] cos_sf, sin_sf;
	logic [8:0]  cut_sf;
	logic [31:0] re_sf, im_sf;
	logic v_sf;
	logic signed [CW-1:0] fc, fs;
	always_comb begin
		case (cq_s[NS])
			2'd0: begin fc = cx_s[NS]; fs = cy_s[NS]; end
			2'd1: begin fc = -cy_s[NS]; fs = cx_s[NS]; end
			2'd2: begin fc = -cx_s[NS]; fs = -cy_s[NS]; end
			default: begin fc = cy_s[NS]; fs = -cx_s[NS]; end
		endcase
	end

	// complex multiply
	logic signed [64:0] p1_sm, p2_sm, p3_sm, p4_sm;
	logic [8:0] cut_sm;
	logic v_sm;
	logic signed [32:0] ma, mb;
	always_comb begin
		if (first_layer_q) begin
			ma = signed'({2'b00, uniform_amp_q});
			mb = '0;
		end else begin
			ma = 33'(signed'(re_sf));
			mb = 33'(signed'(im_sf));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_sf <= fc[31:0];
			sin_sf <= fs[31:0];
			cut_sf <= ccut_s[NS];
			re_sf <= cre_s[NS];
			im_sf <= cim_s[NS];
			p1_sm <= ma * cos_sf;
			p2_sm <= mb * sin_sf;
			p3_sm <= ma * sin_sf;
			p4_sm <= mb * cos_sf;
			cut_sm <= cut_sf;
		end
	end

	// round half up, saturate
	function automatic logic [31:0] rnd_sat(input logic signed [66:0] acc_v);
		logic signed [66:0] t;
		t = (acc_v + 67'sd536870912) >>> 30;
		if (t > 67'sd2147483647) return 32'h7FFF_FFFF;
		if (t < -67'sd2147483648) return 32'h8000_0000;
		return t[31:0];
	endfunction

	logic [31:0] ore, oim;
	assign ore = rnd_sat(67'(p1_sm) - 67'(p2_sm));
	assign oim = rnd_sat(67'(p3_sm) + 67'(p4_sm));

	logic [8:0] cut_q;
	logic [31:0] ore_q, oim_q;
	always_ff @(posedge clk) begin
		if (en) begin
			ore_q <= ore;
			oim_q <= oim;
			cut_q <= cut_sm;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i <= NS; i++) cv_s[i] <= 1'b0;
			v_sf <= 1'b0;
			v_sm <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && s_tuser;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			cv_s[0] <= v_s3;
			for (int i = 0; i < NS; i++) cv_s[i+1] <= cv_s[i];
			v_sf <= cv_s[NS];
			v_sm <= v_sf;
			m_tvalid <= v_sm;
		end
	end

	assign m_tdata = {7'd0, cut_q, oim_q, ore_q};

	// a row load never produces a result
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser) |=> !v_s1)
		else $error("row load entered the datapath");

	// the pipeline only holds while a result waits at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("pipeline stalled without a waiting result");

	// a held result keeps its stage-ahead item in place
	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (v_sm == $past(v_sm)))
		else $error("stage moved during a stall");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the MaxCut phase rotator: row loads, amplitude requests, register phases.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 37;
	localparam logic MODE_ROW = 1'b0;
	localparam logic MODE_AMP = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [3:0]  row_index;
		logic [15:0] row_bits;
		logic [15:0] basis_index;
		logic [31:0] amp_re;
		logic [31:0] amp_im;
	} req_t;

	typedef struct packed {
		logic [8:0]  cut_count;
		logic [31:0] out_im;
		logic [31:0] out_re;
	} rot_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser, m_tvalid, m_tready, cfg_we;
	logic [103:0] s_tdata;
	logic [79:0] m_tdata;
	logic [1:0] cfg_addr;
	logic [31:0] cfg_wdata;

	maxcut_phase_rotator_top dut (.*);

	// predictor state
	logic [15:0] adj_rows [16];
	logic [31:0] half_angle;
	logic        first_layer;
	logic [30:0] uniform_amp;
	logic [4:0]  qubits;

	req_t pending_reqs[$];
	rot_t expected_rots[$];
	int fails = 0;
	int n_rows = 0, n_amps = 0, n_checked = 0;
	bit stim_done = 0;

	function automatic longint round_sat(longint acc);
		longint r;
		r = (acc + (64'sd1 <<< 29)) >>> 30;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r;
	endfunction

	function automatic int atan_tab(int i);
		int t [30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1};
		return t[i];
	endfunction

	function automatic void cordic_cs(logic [31:0] phase, output longint c, output longint s);
		logic [1:0] q;
		logic [31:0] rr;
		longint x, y, z, dx, dy;
		q = 2'((phase + 32'h2000_0000) >> 30);
		rr = phase - {q, 30'd0};
		z = longint'(signed'(rr));
		x = 652032875;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_tab(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_tab(i));
			end
		end
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic void predict_rotation(req_t r);
		int limit;
		logic [31:0] cut, edges, phase;
		logic [15:0] sel;
		longint c, s, a, b, re, im;
		rot_t o;
		if (r.mode == MODE_ROW) begin
			adj_rows[r.row_index] = r.row_bits;
			return;
		end
		limit = (qubits > 16) ? 16 : qubits;
		cut = 0;
		edges = 0;
		for (int i = 0; i < limit; i++) begin
			sel = r.basis_index[i] ? ~r.basis_index : r.basis_index;
			cut += $countones(adj_rows[i] & sel);
			edges += $countones(adj_rows[i]);
		end
		phase = half_angle * (2 * cut - edges);
		cordic_cs(phase, c, s);
		if (first_layer) begin
			re = round_sat(longint'(uniform_amp) * c);
			im = round_sat(longint'(uniform_amp) * s);
		end else begin
			a = longint'(signed'(r.amp_re));
			b = longint'(signed'(r.amp_im));
			re = round_sat(a * c - b * s);
			im = round_sat(a * s + b * c);
		end
		o.out_re = re[31:0];
		o.out_im = im[31:0];
		o.cut_count = cut[8:0];
		expected_rots.push_back(o);
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// driver: bursts with random gaps
	int gap_left = 0, burst_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_tuser <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_rotation(pending_reqs.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 0;
				end else if (pending_reqs.size() > 0) begin
					s_tvalid <= 1;
					s_tuser <= pending_reqs[0].mode;
					s_tdata <= {4'd0, pending_reqs[0].amp_im, pending_reqs[0].amp_re,
						pending_reqs[0].basis_index, pending_reqs[0].row_bits,
						pending_reqs[0].row_index};
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// monitor and receiver stall pattern
	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				rot_t got, want;
				got = rot_t'(m_tdata[72:0]);
				if (expected_rots.size() == 0) begin
					$error("result with no request waiting");
					fails++;
				end else begin
					want = expected_rots.pop_front();
					n_checked++;
					if (got.out_re !== want.out_re) begin
						$error("out_re exp %h got %h", want.out_re, got.out_re); fails++;
					end
					if (got.out_im !== want.out_im) begin
						$error("out_im exp %h got %h", want.out_im, got.out_im); fails++;
					end
					if (got.cut_count !== want.cut_count) begin
						$error("cut_count exp %0d got %0d", want.cut_count, got.cut_count);
						fails++;
					end
				end
			end
			stall_phase = (stall_phase + 1) % 300;
			if (stall_phase < 100) m_tready <= 1;
			else if (stall_phase < 200) m_tready <= ($urandom_range(0, 3) != 0);
			else m_tready <= ($urandom_range(0, 1) != 0) || (stall_phase % 7 == 0);
		end
	end

	task automatic write_reg(mpr_pkg::cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			mpr_pkg::REG_HALF_ANGLE: half_angle = val;
			mpr_pkg::REG_FIRST_LAYER: first_layer = val[0];
			mpr_pkg::REG_UNIFORM_AMP: uniform_amp = val[30:0];
			default: qubits = val[4:0];
		endcase
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_rots.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic void add_row(logic [3:0] idx, logic [15:0] bits);
		req_t r;
		r = '0;
		r.mode = MODE_ROW;
		r.row_index = idx;
		r.row_bits = bits;
		r.basis_index = 16'($urandom);
		r.amp_re = $urandom;
		r.amp_im = $urandom;
		pending_reqs.push_back(r);
		n_rows++;
	endfunction

	function automatic void add_amp(logic [15:0] bi, logic [31:0] re, logic [31:0] im);
		req_t r;
		r.mode = MODE_AMP;
		r.row_index = 4'($urandom);
		r.row_bits = 16'($urandom);
		r.basis_index = bi;
		r.amp_re = re;
		r.amp_im = im;
		pending_reqs.push_back(r);
		n_amps++;
	endfunction

	function automatic logic [31:0] rand_amp();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h4000_0000;
			3: return 32'hc000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		cfg_we = 0; cfg_addr = mpr_pkg::REG_HALF_ANGLE; cfg_wdata = '0;
		foreach (adj_rows[i]) adj_rows[i] = '0;
		half_angle = 0; first_layer = 1; uniform_amp = 0; qubits = 16;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// reset defaults: zero amplitude, empty graph
		add_amp(16'hffff, 32'h7fff_ffff, 32'h8000_0000);
		drain();

		// directed: full graph, max cut, first layer at full amplitude
		write_reg(mpr_pkg::REG_HALF_ANGLE, 32'h0100_0000);
		write_reg(mpr_pkg::REG_UNIFORM_AMP, 32'h4000_0000);
		for (int i = 0; i < 16; i++) add_row(4'(i), 16'hffff);
		add_amp(16'h0000, 0, 0);
		add_amp(16'h5555, 0, 0);
		add_amp(16'hffff, 0, 0);
		add_amp(16'h00ff, 0, 0);
		drain();
		// directed: rotate extremes, qubit count out of range, zero and one
		write_reg(mpr_pkg::REG_FIRST_LAYER, 0);
		write_reg(mpr_pkg::REG_QUBITS, 31);
		write_reg(mpr_pkg::REG_HALF_ANGLE, 32'h8000_0000);
		add_amp(16'haaaa, 32'h8000_0000, 32'h8000_0000);
		add_amp(16'h1234, 32'h7fff_ffff, 32'h7fff_ffff);
		add_amp(16'h8001, 32'h7fff_ffff, 32'h8000_0000);
		drain();
		write_reg(mpr_pkg::REG_QUBITS, 0);
		add_amp(16'hbeef, 32'h4000_0000, 32'hc000_0000);
		drain();
		write_reg(mpr_pkg::REG_QUBITS, 1);
		write_reg(mpr_pkg::REG_HALF_ANGLE, 32'h7fff_ffff);
		add_row(4'd0, 16'h8001);
		add_amp(16'h8000, 32'h7fff_ffff, 0);
		add_amp(16'h0001, 0, 32'h8000_0000);
		drain();

		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(mpr_pkg::REG_HALF_ANGLE, rand_angle());
			write_reg(mpr_pkg::REG_FIRST_LAYER, 32'(ph % 3 == 0));
			write_reg(mpr_pkg::REG_UNIFORM_AMP, (ph % 4 == 0) ? 32'h4000_0000 :
				(ph % 4 == 1) ? 32'h7fff_ffff : $urandom_range(0, 32'h4000_0000));
			write_reg(mpr_pkg::REG_QUBITS, (ph % 5 == 0) ? $urandom_range(17, 31) :
				(ph % 5 == 1) ? 16 : $urandom_range(1, 16));
			for (int k = 0; k < 125; k++) begin
				if ($urandom_range(0, 9) == 0)
					add_row(4'($urandom), ($urandom_range(0, 5) == 0) ? 16'hffff :
						16'($urandom));
				else
					add_amp(16'($urandom), rand_amp(), rand_amp());
			end
			drain();
		end
		stim_done = 1;
		$display("Covered %0d row loads and %0d amplitude requests, %0d results checked.",
			n_rows, n_amps, n_checked);
		$display("Register phases spanned both layer modes and qubit counts 0 to 31.");
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
